>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the bit writer RTL.
// Depends on nothing; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check on clk, disabled while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also runs during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/egbw_pkg.sv
// Package for the Exp-Golomb bit writer: opcodes, widths, stage types.
// Used by every module of the block; depends on nothing.
package egbw_pkg;

  localparam logic [2:0] OP_RAW   = 3'd0;
  localparam logic [2:0] OP_UE    = 3'd1;
  localparam logic [2:0] OP_SE    = 3'd2;
  localparam logic [2:0] OP_TRAIL = 3'd3;
  localparam logic [2:0] OP_FLUSH = 3'd4;

  localparam int WORD_W     = 32;
  localparam int CODE_W     = 64;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Formed code, left-aligned in bits, len in 0..63.
  typedef struct packed {
    logic [5:0]        len;
    logic [CODE_W-1:0] bits;
    logic              flush;
  } code_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [2:0]        byte_count;
    logic              last;
  } res_t;

  // Up to two results pushed per cycle, r0 first.
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  // Position of the highest set bit.
  function automatic logic [4:0] msb_index(input logic [WORD_W-1:0] x);
    logic [4:0] idx;
    idx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (x[i]) idx = i[4:0];
    end
    return idx;
  endfunction

endpackage

>>> hw/rtl/egbw_code_former.sv
// Input stage: turns an item into a left-aligned code and a length, registered.
// Depends on egbw_pkg.
module egbw_code_former import egbw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [5:0]  bit_count,
  input  logic [31:0] value,
  input  logic [31:0] signed_value,
  output logic        code_vld,
  output code_t       code,
  input  logic        take
);

  logic [5:0]  cnt_sat;
  logic [32:0] mask;
  logic [31:0] mag;
  logic [31:0] se_num;
  logic [31:0] ue_num;
  logic [31:0] ue_code;
  logic [5:0]  ue_len;
  logic [5:0]  len;
  logic [63:0] bits;
  logic        flush;
  logic        item_ok;
  code_t       code_next;

  always_comb begin
    cnt_sat = (bit_count > 6'd32) ? 6'd32 : bit_count;
    mask    = (33'd1 << cnt_sat) - 33'd1;

    mag = 32'd0 - signed_value;
    if (mag[31]) mag = 32'h7fff_ffff;
    if (signed_value == 32'd0)   se_num = 32'd0;
    else if (!signed_value[31])  se_num = {signed_value[30:0], 1'b0} - 32'd1;
    else                         se_num = {mag[30:0], 1'b0};

    ue_num = (opcode == OP_SE) ? se_num : value;
    if (ue_num == 32'hffff_ffff) ue_num = 32'hffff_fffe;
    ue_code = ue_num + 32'd1;
    ue_len  = {msb_index(ue_code), 1'b1};

    len     = '0;
    bits    = '0;
    flush   = 1'b0;
    item_ok = 1'b1;
    case (opcode)
      OP_RAW: begin
        len     = cnt_sat;
        bits    = {32'd0, value & mask[31:0]};
        item_ok = (cnt_sat != 6'd0);
      end
      OP_UE, OP_SE: begin
        len  = ue_len;
        bits = {32'd0, ue_code};
      end
      OP_TRAIL: begin
        len   = 6'd1;
        bits  = 64'd1;
        flush = 1'b1;
      end
      OP_FLUSH: flush = 1'b1;
      default:  item_ok = 1'b0;
    endcase

    code_next.len   = len;
    code_next.bits  = bits << (7'd64 - {1'b0, len});
    code_next.flush = flush;
  end

  assign in_ready = !code_vld || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_vld <= 1'b0;
    end else if (in_ready) begin
      code_vld <= in_valid && item_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      code <= code_next;
    end
  end

endmodule

>>> hw/rtl/egbw_packer.sv
// Packer: merges a code with the held bits, splits off full words and flushes.
// Depends on egbw_pkg and assert_macros.svh.
`include "assert_macros.svh"
module egbw_packer import egbw_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  code_vld,
  input  code_t code,
  input  logic  space_ok,
  output logic  take,
  output push_t push
);

  logic [31:0] acc;
  logic [4:0]  held;
  logic [31:0] acc_next;
  logic [4:0]  held_next;
  logic [95:0] window;
  logic [6:0]  total;
  logic [4:0]  rem;
  logic [1:0]  nfull;
  logic [31:0] leftover;
  logic [5:0]  rem_up;
  res_t        fl_res;
  res_t        w0_res;
  res_t        w1_res;

  always_comb begin
    take   = code_vld && space_ok;
    window = {acc, 64'd0} | ({code.bits, 32'd0} >> held);
    total  = {2'd0, held} + {1'b0, code.len};
    rem    = total[4:0];
    nfull  = total[6] ? 2'd2 : (total[5] ? 2'd1 : 2'd0);
    case (nfull)
      2'd2:    leftover = window[31:0];
      2'd1:    leftover = window[63:32];
      default: leftover = window[95:64];
    endcase
    rem_up = {1'b0, rem} + 6'd7;

    w0_res = '{word: window[95:64], byte_count: 3'd4, last: 1'b0};
    w1_res = '{word: window[63:32], byte_count: 3'd4, last: 1'b0};
    fl_res = '{word: leftover, byte_count: rem_up[5:3], last: 1'b1};

    push.cnt = '0;
    push.r0  = fl_res;
    push.r1  = fl_res;
    if (take) begin
      push.cnt = nfull + {1'b0, code.flush};
      if (nfull != 2'd0) push.r0 = w0_res;
      if (nfull == 2'd2) push.r1 = w1_res;
      if (push.cnt == 2'd1) push.r0.last = 1'b1;
      else                  push.r1.last = 1'b1;
    end

    acc_next  = acc;
    held_next = held;
    if (take) begin
      acc_next  = code.flush ? 32'd0 : leftover;
      held_next = code.flush ? 5'd0  : rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      held <= '0;
    end else begin
      acc  <= acc_next;
      held <= held_next;
    end
  end

  `ASSERT_CLK(a_flush_clears, (take && code.flush) |=> (held == '0 && acc == '0), "bits kept")
  `ASSERT_ALWAYS(a_idle_no_push, !take |-> (push.cnt == 2'd0), "result pushed without an item")

endmodule

>>> hw/rtl/egbw_result_fifo.sv
// Result queue: takes up to two results a cycle, presents one on the master side.
// Depends on egbw_pkg and assert_macros.svh.
`include "assert_macros.svh"
module egbw_result_fifo import egbw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  push_t       push,
  output logic        space_ok,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  res_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] rp;
  logic [CNT_W-1:0] count;
  logic             pop;
  res_t             head;

  assign head          = mem[rp];
  assign m_axis_tvalid = (count != '0);
  assign m_axis_tdata  = head.word;
  assign m_axis_tuser  = head.byte_count;
  assign m_axis_tlast  = head.last;
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign space_ok      = (count <= CNT_W'(FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem[wp] <= push.r0;
    if (push.cnt == 2'd2) mem[wp + PTR_W'(1)] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + PTR_W'(push.cnt);
      rp    <= rp + PTR_W'(pop);
      count <= count + CNT_W'(push.cnt) - CNT_W'(pop);
    end
  end

  `ASSERT_CLK(a_cnt_bound, count <= CNT_W'(FIFO_DEPTH), "result queue overflow")
  `ASSERT_CLK(a_push_fits, (push.cnt != 2'd0) |-> (count <= CNT_W'(FIFO_DEPTH - 2)), "no room")

endmodule

>>> hw/rtl/exp_golomb_bit_writer_unit.sv
// Exp-Golomb bit writer top level: code stage, packer, result queue.
// Depends on egbw_pkg, egbw_code_former, egbw_packer, egbw_result_fifo.
// Path: an accepted item is registered in the code stage; the packer then merges it and
// writes any finished results into the result queue, which drives m_axis. Throughput: one
// item per cycle while the queue has room; the output moves one result per cycle.
// Reset (rst, synchronous): empties the accumulator and the result queue.
module exp_golomb_bit_writer_unit import egbw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // bit_count[5:0], value[37:6], signed_value[69:38], zero
  input  logic [2:0]  s_axis_tuser,  // opcode[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // word[31:0]
  output logic [2:0]  m_axis_tuser,  // byte_count[2:0]
  output logic        m_axis_tlast
);

  logic  code_vld;
  code_t code;
  logic  take;
  logic  space_ok;
  push_t push;

  egbw_code_former u_former (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .opcode       (s_axis_tuser),
    .bit_count    (s_axis_tdata[5:0]),
    .value        (s_axis_tdata[37:6]),
    .signed_value (s_axis_tdata[69:38]),
    .code_vld     (code_vld),
    .code         (code),
    .take         (take)
  );

  egbw_packer u_packer (
    .clk      (clk),
    .rst      (rst),
    .code_vld (code_vld),
    .code     (code),
    .space_ok (space_ok),
    .take     (take),
    .push     (push)
  );

  egbw_result_fifo u_fifo (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .space_ok      (space_ok),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
